// ===== rtl/plid_pkg.sv =====
package plid_pkg;

    // List size and derived widths
    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 5;
    localparam int DATA_W   = 32;

    // Request types
    localparam logic [1:0] REQ_INS  = 2'd0;
    localparam logic [1:0] REQ_DEL  = 2'd1;
    localparam logic [1:0] REQ_DUMP = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_BAD_INS = 2'd1;
    localparam logic [1:0] ST_BAD_DEL = 2'd2;
    localparam logic [1:0] ST_ENTRY   = 2'd3;

    // Cell commands
    localparam logic [1:0] CMD_HOLD = 2'd0;
    localparam logic [1:0] CMD_INS  = 2'd1;
    localparam logic [1:0] CMD_DEL  = 2'd2;
    localparam logic [1:0] CMD_ROT  = 2'd3;

    // Command broadcast to every cell
    typedef struct packed {
        logic [1:0]       op;
        logic [POS_W-1:0] pos;
        logic [CNT_W-1:0] cnt;
    } plid_cmd_t;

endpackage

// ===== rtl/plid_cell.sv =====
module plid_cell (
    input  logic                          clk,
    input  plid_pkg::plid_cmd_t           cmd,
    input  logic [plid_pkg::IDX_W-1:0]    idx,
    input  logic [plid_pkg::DATA_W-1:0]   left_data,
    input  logic [plid_pkg::DATA_W-1:0]   right_data,
    input  logic [plid_pkg::DATA_W-1:0]   head_data,
    input  logic [plid_pkg::DATA_W-1:0]   new_value,
    output logic [plid_pkg::DATA_W-1:0]   data
);

    logic [plid_pkg::DATA_W-1:0] data_reg;
    logic [plid_pkg::DATA_W-1:0] data_next;
    logic [plid_pkg::POS_W-1:0]  my_pos;
    logic [plid_pkg::CNT_W-1:0]  my_cnt;
    logic [plid_pkg::CNT_W-1:0]  tail_idx;

    assign my_pos   = plid_pkg::POS_W'(idx);
    assign my_cnt   = plid_pkg::CNT_W'(idx);
    assign tail_idx = plid_pkg::CNT_W'(cmd.cnt - 1'b1);

    // Local decision from the broadcast command and this cell's place
    always_comb
    begin
        data_next = data_reg;
        case (cmd.op)
            plid_pkg::CMD_INS:
            begin
                if (my_pos == cmd.pos)
                    data_next = new_value;
                else if (my_pos > cmd.pos)
                    data_next = left_data;
            end
            plid_pkg::CMD_DEL:
            begin
                if (my_pos >= cmd.pos)
                    data_next = right_data;
            end
            plid_pkg::CMD_ROT:
            begin
                // tail of the live list takes the head, others in the live list move one place toward the head
                if (my_cnt == tail_idx)
                    data_next = head_data;
                else if (my_cnt < cmd.cnt)
                    data_next = right_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== rtl/positional_list_insert_delete_top.sv =====
// Insert, delete and other single-result requests: result registered on acceptance,
// valid in the next cycle; one such request per cycle while the result side keeps
// up and no dump runs. Dump of N entries: after acceptance, N results, one per cycle
// with the result side free (cell chain rotates once per entry); empty list gives one.
// Reset (rst_n, async, low) clears the length and control; cell data is not reset.
module positional_list_insert_delete_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 req_valid,
    output logic                                 req_stall,
    input  logic [1:0]                           req_type,
    input  logic [plid_pkg::POS_W-1:0]           position,
    input  logic signed [plid_pkg::DATA_W-1:0]   value,
    output logic                                 res_valid,
    input  logic                                 res_stall,
    output logic [1:0]                           status,
    output logic signed [plid_pkg::DATA_W-1:0]   entry_value,
    output logic [plid_pkg::CNT_W-1:0]           length,
    output logic                                 last
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DUMP = 1'b1;

    logic                          state_reg, state_next;
    logic [plid_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [plid_pkg::IDX_W-1:0]    dump_idx_reg, dump_idx_next;
    logic                          out_valid_reg, out_valid_next;
    logic [1:0]                    status_reg, status_next;
    logic [plid_pkg::DATA_W-1:0]   entry_reg, entry_next;
    logic [plid_pkg::CNT_W-1:0]    length_reg, length_next;
    logic                          last_reg, last_next;

    logic                          out_free;
    logic                          req_acc;
    logic                          out_load;
    logic                          dump_last;
    plid_pkg::plid_cmd_t           cmd;
    logic [plid_pkg::DATA_W-1:0]   cell_data [plid_pkg::CAPACITY];

    assign out_free  = !out_valid_reg || !res_stall;
    assign req_stall = (state_reg == ST_DUMP) || !out_free;
    assign req_acc   = req_valid && !req_stall;
    assign dump_last = (plid_pkg::CNT_W'(dump_idx_reg)
                        == plid_pkg::CNT_W'(count_reg - 1'b1));

    // Request decode, dump sequencing and output register load
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        dump_idx_next = dump_idx_reg;
        out_load      = 1'b0;
        status_next   = plid_pkg::ST_DONE;
        entry_next    = '0;
        length_next   = count_reg;
        last_next     = 1'b1;
        cmd.op        = plid_pkg::CMD_HOLD;
        cmd.pos       = position;
        cmd.cnt       = count_reg;

        if (state_reg == ST_DUMP)
        begin
            if (out_free)
            begin
                out_load      = 1'b1;
                status_next   = plid_pkg::ST_ENTRY;
                entry_next    = cell_data[0];
                last_next     = dump_last;
                cmd.op        = plid_pkg::CMD_ROT;
                dump_idx_next = plid_pkg::IDX_W'(dump_idx_reg + 1'b1);
                if (dump_last)
                    state_next = ST_IDLE;
            end
        end
        else if (req_acc)
        begin
            out_load = 1'b1;
            case (req_type)
                plid_pkg::REQ_INS:
                begin
                    if ((position > plid_pkg::POS_W'(count_reg))
                        || (count_reg >= plid_pkg::CNT_W'(plid_pkg::CAPACITY)))
                    begin
                        status_next = plid_pkg::ST_BAD_INS;
                    end
                    else
                    begin
                        cmd.op      = plid_pkg::CMD_INS;
                        count_next  = plid_pkg::CNT_W'(count_reg + 1'b1);
                        length_next = count_next;
                    end
                end
                plid_pkg::REQ_DEL:
                begin
                    if (position >= plid_pkg::POS_W'(count_reg))
                    begin
                        status_next = plid_pkg::ST_BAD_DEL;
                    end
                    else
                    begin
                        cmd.op      = plid_pkg::CMD_DEL;
                        count_next  = plid_pkg::CNT_W'(count_reg - 1'b1);
                        length_next = count_next;
                    end
                end
                plid_pkg::REQ_DUMP:
                begin
                    if (count_reg != '0)
                    begin
                        out_load      = 1'b0;
                        state_next    = ST_DUMP;
                        dump_idx_next = '0;
                    end
                end
                default:
                begin
                    status_next = plid_pkg::ST_DONE;
                end
            endcase
        end

        if (out_load)
            out_valid_next = 1'b1;
        else
            out_valid_next = out_valid_reg && res_stall;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            dump_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dump_idx_reg  <= dump_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status_reg <= status_next;
            entry_reg  <= entry_next;
            length_reg <= length_next;
            last_reg   <= last_next;
        end
    end

    // Chain of entry cells
    for (genvar i = 0; i < plid_pkg::CAPACITY; i++)
    begin : g_cell
        logic [plid_pkg::DATA_W-1:0] left_w;
        logic [plid_pkg::DATA_W-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_mid_l
            assign left_w = cell_data[i-1];
        end

        if (i == plid_pkg::CAPACITY - 1)
        begin : g_lastc
            assign right_w = cell_data[i];
        end
        else
        begin : g_mid_r
            assign right_w = cell_data[i+1];
        end

        plid_cell u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .idx        (plid_pkg::IDX_W'(i)),
            .left_data  (left_w),
            .right_data (right_w),
            .head_data  (cell_data[0]),
            .new_value  (value),
            .data       (cell_data[i])
        );
    end

    assign res_valid   = out_valid_reg;
    assign status      = status_reg;
    assign entry_value = entry_reg;
    assign length      = length_reg;
    assign last        = last_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= plid_pkg::CNT_W'(plid_pkg::CAPACITY))
        else $error("list length above capacity");

    a_dump_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DUMP |-> count_reg != '0)
        else $error("dump running on an empty list");

    a_dump_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DUMP && out_free && dump_last) |=> state_reg == ST_IDLE)
        else $error("dump did not finish after its last entry");

    a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (req_acc && req_type == plid_pkg::REQ_INS && status_next == plid_pkg::ST_DONE)
        |=> count_reg == plid_pkg::CNT_W'($past(count_reg) + 1'b1))
        else $error("insert did not grow the list");

    a_count_fixed_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DUMP |=> $stable(count_reg))
        else $error("length changed during dump");

endmodule

// ===== sim/positional_list_insert_delete_top_test.sv =====
module positional_list_insert_delete_top_test;

    // Request type the block leaves unused; it must still answer once
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int TIMEOUT_CYCLES = 400000;

    typedef struct packed {
        logic [1:0]                          status;
        logic signed [plid_pkg::DATA_W-1:0]  entry_value;
        logic [plid_pkg::CNT_W-1:0]          length;
        logic                                last;
    } list_result_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                req_valid = 1'b0;
    logic                                req_stall;
    logic [1:0]                          req_type = plid_pkg::REQ_INS;
    logic [plid_pkg::POS_W-1:0]          position = '0;
    logic signed [plid_pkg::DATA_W-1:0]  value = '0;
    logic                                res_valid;
    logic                                res_stall = 1'b0;
    logic [1:0]                          status;
    logic signed [plid_pkg::DATA_W-1:0]  entry_value;
    logic [plid_pkg::CNT_W-1:0]          length;
    logic                                last;

    // Shadow copy of the list contents and length
    logic signed [plid_pkg::DATA_W-1:0]  list_store [plid_pkg::CAPACITY];
    int                                  list_len = 0;
    list_result_t                        pending_results [$];

    int  error_count = 0;
    int  cycle_count = 0;
    bit  sender_gaps = 1'b1;
    int  burst_left = 0;
    int  stall_mode = 0;
    int  stall_phase_left = 0;

    positional_list_insert_delete_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_type    (req_type),
        .position    (position),
        .value       (value),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .status      (status),
        .entry_value (entry_value),
        .length      (length),
        .last        (last)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Run limit
    initial
    begin
        while (cycle_count < TIMEOUT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // Apply one accepted request to the shadow list, queue its results
    task automatic apply_list_request(input logic [1:0] kind,
                                      input logic [plid_pkg::POS_W-1:0] pos,
                                      input logic signed [plid_pkg::DATA_W-1:0] val);
        list_result_t r;
        int i;
        r = '{status: plid_pkg::ST_DONE, entry_value: '0, length: '0, last: 1'b1};
        case (kind)
            plid_pkg::REQ_INS:
            begin
                if (pos > list_len || list_len >= plid_pkg::CAPACITY)
                    r.status = plid_pkg::ST_BAD_INS;
                else
                begin
                    for (i = list_len; i > pos; i--)
                        list_store[i] = list_store[i-1];
                    list_store[pos] = val;
                    list_len++;
                end
            end
            plid_pkg::REQ_DEL:
            begin
                if (pos >= list_len)
                    r.status = plid_pkg::ST_BAD_DEL;
                else
                begin
                    for (i = pos; i + 1 < list_len; i++)
                        list_store[i] = list_store[i+1];
                    list_len--;
                end
            end
            plid_pkg::REQ_DUMP:
            begin
                if (list_len != 0)
                begin
                    for (i = 0; i < list_len; i++)
                    begin
                        r.status      = plid_pkg::ST_ENTRY;
                        r.entry_value = list_store[i];
                        r.length      = plid_pkg::CNT_W'(list_len);
                        r.last        = (i + 1 == list_len);
                        pending_results.push_back(r);
                    end
                    return;
                end
            end
            default: ;
        endcase
        r.length = plid_pkg::CNT_W'(list_len);
        pending_results.push_back(r);
    endtask

    // Send one request: optional gap between bursts, then hold until accepted
    task automatic send_request(input logic [1:0] kind,
                                input logic [plid_pkg::POS_W-1:0] pos,
                                input logic signed [plid_pkg::DATA_W-1:0] val);
        int gap;
        if (sender_gaps && burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 10);
        end
        if (burst_left > 0)
            burst_left--;
        req_valid <= 1'b1;
        req_type  <= kind;
        position  <= pos;
        value     <= val;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        apply_list_request(kind, pos, val);
    endtask

    // Hold off the sender until every expected result has come back
    task automatic wait_drained();
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic signed [plid_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return '0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [plid_pkg::POS_W-1:0] pick_insert_pos();
        if ($urandom_range(0, 99) < 85)
            return plid_pkg::POS_W'($urandom_range(0, list_len));
        return plid_pkg::POS_W'($urandom_range(0, 31));
    endfunction

    function automatic logic [plid_pkg::POS_W-1:0] pick_delete_pos();
        if (list_len > 0 && $urandom_range(0, 99) < 85)
            return plid_pkg::POS_W'($urandom_range(0, list_len - 1));
        return plid_pkg::POS_W'($urandom_range(0, 31));
    endfunction

    // Result checker and receiver stall pattern
    always @(posedge clk)
    begin
        list_result_t got;
        list_result_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            got = '{status: status, entry_value: entry_value, length: length, last: last};
            if (pending_results.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result: status %0d value %0d length %0d last %0b",
                             got.status, got.entry_value, got.length, got.last);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display({"mismatch: exp st %0d val %0d len %0d last %0b,",
                                  " got st %0d val %0d len %0d last %0b"},
                                 want.status, want.entry_value, want.length, want.last,
                                 got.status, got.entry_value, got.length, got.last);
                end
            end
        end
        // pick a new stall behavior when the current stall phase runs out
        if (stall_phase_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_phase_left = 48;
        end
        else
            stall_phase_left--;
        case (stall_mode)
            0: res_stall <= 1'b0;
            1: res_stall <= ($urandom_range(0, 3) == 0);
            2: res_stall <= $urandom_range(0, 1);
            default: res_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // Requests on an empty list, unused type, small edits at front, middle and end
    task automatic test_directed_edits();
        send_request(plid_pkg::REQ_DUMP, 5'd7, 32'sh12345678);
        send_request(plid_pkg::REQ_DEL, 5'd0, '0);
        send_request(plid_pkg::REQ_INS, 5'd1, 32'sd5);
        send_request(REQ_UNUSED, 5'd31, -32'sd1);
        send_request(plid_pkg::REQ_INS, 5'd0, 32'sh80000000);
        send_request(plid_pkg::REQ_INS, 5'd1, 32'sh7fffffff);
        send_request(plid_pkg::REQ_INS, 5'd1, -32'sd1);
        send_request(plid_pkg::REQ_INS, 5'd0, '0);
        send_request(plid_pkg::REQ_INS, 5'd5, 32'sd9);
        send_request(plid_pkg::REQ_DUMP, 5'd31, '1);
        send_request(plid_pkg::REQ_DEL, 5'd3, '0);
        send_request(plid_pkg::REQ_DEL, 5'd0, '0);
        send_request(plid_pkg::REQ_DEL, 5'd31, '0);
        send_request(plid_pkg::REQ_INS, 5'd31, 32'sd1);
        send_request(REQ_UNUSED, 5'd2, 32'sh55aa55aa);
        send_request(plid_pkg::REQ_DUMP, 5'd0, '0);
        wait_drained();
    endtask

    // Fill to capacity, then hit the full-list and out-of-range cases
    task automatic test_full_list();
        while (list_len < plid_pkg::CAPACITY)
            send_request(plid_pkg::REQ_INS,
                         plid_pkg::POS_W'($urandom_range(0, list_len)), pick_value());
        send_request(plid_pkg::REQ_INS, 5'd16, 32'sd1);
        send_request(plid_pkg::REQ_INS, 5'd0, 32'sd2);
        send_request(plid_pkg::REQ_DEL, 5'd16, '0);
        send_request(plid_pkg::REQ_DUMP, 5'd3, '0);
        send_request(plid_pkg::REQ_DEL, 5'd15, '0);
        send_request(plid_pkg::REQ_INS, 5'd15, 32'sh7fffffff);
        send_request(REQ_UNUSED, 5'd0, '0);
        send_request(plid_pkg::REQ_DUMP, 5'd0, '0);
        wait_drained();
    endtask

    // Weighted random operations; unused type has a small fixed weight
    task automatic run_random_phase(input int n, input int w_ins, input int w_del,
                                    input int w_dump);
        int k;
        int pick;
        for (k = 0; k < n; k++)
        begin
            pick = $urandom_range(0, w_ins + w_del + w_dump + 3);
            if (pick < w_ins)
                send_request(plid_pkg::REQ_INS, pick_insert_pos(), pick_value());
            else if (pick < w_ins + w_del)
                send_request(plid_pkg::REQ_DEL, pick_delete_pos(), pick_value());
            else if (pick < w_ins + w_del + w_dump)
                send_request(plid_pkg::REQ_DUMP,
                             plid_pkg::POS_W'($urandom_range(0, 31)), pick_value());
            else
                send_request(REQ_UNUSED,
                             plid_pkg::POS_W'($urandom_range(0, 31)), pick_value());
        end
    endtask

    task automatic test_random_mix();
        sender_gaps = 1'b1;
        run_random_phase(70, 45, 30, 15);
        wait_drained();
        run_random_phase(70, 70, 15, 10);
        sender_gaps = 1'b0;
        run_random_phase(70, 20, 60, 10);
        wait_drained();
        sender_gaps = 1'b1;
        run_random_phase(70, 40, 30, 40);
        wait_drained();
    endtask

    // Empty the list completely and check the empty-list answers again
    task automatic test_drain_list();
        while (list_len > 0)
            send_request(plid_pkg::REQ_DEL,
                         plid_pkg::POS_W'($urandom_range(0, list_len - 1)), '0);
        send_request(plid_pkg::REQ_DEL, 5'd0, '0);
        send_request(plid_pkg::REQ_DUMP, 5'd0, '0);
        wait_drained();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_edits();
        test_full_list();
        test_random_mix();
        test_drain_list();
        repeat (20) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/plid_pkg.sv
rtl/plid_cell.sv
rtl/positional_list_insert_delete_top.sv
sim/positional_list_insert_delete_top_test.sv
